// File: rtl/core/mbps_pkg.sv
// Package for the masked byte pattern search unit.
// Holds sizing constants, configuration register indices and shared types.
// No dependencies.
package mbps_pkg;

  localparam int MAX_PATTERN_BYTES = 16;
  localparam int OFFSET_BITS       = 32;

  localparam int LEN_W    = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int IDX_W    = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;
  localparam int RES_OFFSET_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW    = 2'd0,
    CFG_PATTERN_HIGH   = 2'd1,
    CFG_CARE_MASK      = 2'd2,
    CFG_PATTERN_LENGTH = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [63:0] pattern_high;
    logic [63:0] pattern_low;
    logic [15:0] care_mask;
    logic [4:0]  pattern_length;
  } cfg_t;

  typedef logic [MAX_PATTERN_BYTES-1:0][7:0] window_t;

endpackage

// File: rtl/core/mbps_window_match.sv
// Masked compare of the byte window against the configured signature.
// Purely combinational; uses mbps_pkg for sizes and the configuration type.
module mbps_window_match (
  input  mbps_pkg::window_t             window,
  input  mbps_pkg::cfg_t                cfg,
  input  logic [mbps_pkg::LEN_W-1:0]    len,
  output logic                          hit
);

  logic [127:0]                                 pattern;
  logic [mbps_pkg::MAX_PATTERN_BYTES-1:0]       byte_ok;

  assign pattern = {cfg.pattern_high, cfg.pattern_low};

  always_comb begin
    logic [mbps_pkg::LEN_W-1:0] age;
    for (int j = 0; j < mbps_pkg::MAX_PATTERN_BYTES; j++) begin
      age = len - mbps_pkg::LEN_W'(1) - mbps_pkg::LEN_W'(j);
      byte_ok[j] = (mbps_pkg::LEN_W'(j) >= len) || !cfg.care_mask[j] ||
                   (window[age[mbps_pkg::IDX_W-1:0]] == pattern[j*8 +: 8]);
    end
  end

  assign hit = &byte_ok;

endmodule

// File: rtl/core/masked_byte_pattern_search_unit.sv
// Top level of the masked byte pattern search unit.
// Depends on mbps_pkg and mbps_window_match.
//
// Streams a region one byte per request and reports, on the byte marked
// end_of_region, whether the signature matched and the offset of its first
// match. One byte is taken every cycle; a byte goes through an input
// register, the window compare and the result register, and a result
// is registered once its last byte leaves the input register. Input stalls only
// when a region's last byte is pending while the previous result has not
// yet been taken. Configuration writes land at once and are meant for
// idle periods.
module masked_byte_pattern_search_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_data_byte,
  input  logic                               in_end_of_region,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_found,
  output logic [mbps_pkg::RES_OFFSET_W-1:0]  out_match_offset
);

  mbps_pkg::cfg_t                         cfg_r;
  logic                                   s1_valid_r;
  logic [7:0]                             s1_byte_r;
  logic                                   s1_last_r;
  mbps_pkg::window_t                      window_r, window_nxt;
  logic [mbps_pkg::OFFSET_BITS-1:0]       count_r, count_nxt;
  logic                                   match_seen_r, match_seen_nxt;
  logic [mbps_pkg::OFFSET_BITS-1:0]       first_r, first_nxt;
  logic                                   out_valid_r;
  logic                                   out_found_r;
  logic [mbps_pkg::RES_OFFSET_W-1:0]      out_offset_r;

  logic                                   s1_fire;
  logic                                   s1_adv;
  logic                                   saturated;
  logic [mbps_pkg::LEN_W-1:0]             len_eff;
  logic                                   hit;
  logic                                   record;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_low    <= '0;
      cfg_r.pattern_high   <= '0;
      cfg_r.care_mask      <= 16'hFFFF;
      cfg_r.pattern_length <= 5'd1;
    end else if (cfg_we) begin
      unique case (mbps_pkg::cfg_reg_t'(cfg_index))
        mbps_pkg::CFG_PATTERN_LOW:    cfg_r.pattern_low    <= cfg_wdata;
        mbps_pkg::CFG_PATTERN_HIGH:   cfg_r.pattern_high   <= cfg_wdata;
        mbps_pkg::CFG_CARE_MASK:      cfg_r.care_mask      <= cfg_wdata[15:0];
        mbps_pkg::CFG_PATTERN_LENGTH: cfg_r.pattern_length <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign s1_adv   = !s1_last_r || !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_end_of_region;
    end
  end

  // window compare
  assign len_eff = (cfg_r.pattern_length > 5'(mbps_pkg::MAX_PATTERN_BYTES)) ?
                   mbps_pkg::LEN_W'(mbps_pkg::MAX_PATTERN_BYTES) :
                   mbps_pkg::LEN_W'(cfg_r.pattern_length);

  always_comb begin
    window_nxt[0] = s1_byte_r;
    for (int k = 1; k < mbps_pkg::MAX_PATTERN_BYTES; k++) begin
      window_nxt[k] = window_r[k-1];
    end
  end

  mbps_window_match u_match (
    .window (window_nxt),
    .cfg    (cfg_r),
    .len    (len_eff),
    .hit    (hit)
  );

  assign saturated = &count_r;
  assign count_nxt = saturated ? count_r : count_r + mbps_pkg::OFFSET_BITS'(1);
  assign record    = !saturated && !match_seen_r && (len_eff != '0) &&
                     (count_nxt >= mbps_pkg::OFFSET_BITS'(len_eff)) && hit;
  assign match_seen_nxt = match_seen_r || record;
  assign first_nxt = record ? count_nxt - mbps_pkg::OFFSET_BITS'(len_eff) : first_r;

  // region state
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      window_r <= window_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      match_seen_r <= 1'b0;
      first_r      <= '0;
    end else if (s1_fire) begin
      if (s1_last_r) begin
        count_r      <= '0;
        match_seen_r <= 1'b0;
        first_r      <= '0;
      end else begin
        count_r      <= count_nxt;
        match_seen_r <= match_seen_nxt;
        first_r      <= first_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_found_r  <= match_seen_nxt;
      out_offset_r <= match_seen_nxt ? mbps_pkg::RES_OFFSET_W'(first_nxt) : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_match_offset = out_offset_r;

  // checks
  a_no_match_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_offset_r == '0)
    else $error("offset not zero on a miss");

  a_region_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last_r |=> count_r == '0 && !match_seen_r)
    else $error("region state not cleared after last byte");

  a_match_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    match_seen_r && !(s1_fire && s1_last_r) |=> match_seen_r && $stable(first_r))
    else $error("recorded match lost within region");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && !s1_last_r |=> count_r >= $past(count_r))
    else $error("byte count went backwards");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !(s1_fire && s1_last_r))
    else $error("pending result overwritten");

endmodule

// File: tb/sv/mbps_search_checker.sv
// Checker for the masked byte pattern search unit: follows register writes and
// byte requests, predicts each region's result and compares it with the output.
// Depends on mbps_pkg.
module mbps_search_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [7:0]                        in_data_byte,
  input  logic                              in_end_of_region,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic                              out_found,
  input  logic [mbps_pkg::RES_OFFSET_W-1:0] out_match_offset,
  output int                                fail_count,
  output int                                results_open,
  output int                                results_taken,
  output int                                results_found
);

  typedef struct packed {
    logic                              found;
    logic [mbps_pkg::RES_OFFSET_W-1:0] offset;
  } scan_result_t;

  logic [63:0]                      sig_low;
  logic [63:0]                      sig_high;
  logic [15:0]                      sig_care;
  logic [4:0]                       sig_len;
  mbps_pkg::window_t                recent;
  logic [mbps_pkg::OFFSET_BITS-1:0] region_count;
  logic                             region_hit;
  logic [mbps_pkg::OFFSET_BITS-1:0] hit_offset;
  scan_result_t                     pending_results[$];
  int                               faults;
  int                               taken;
  int                               hits;

  function automatic logic signature_fits(mbps_pkg::window_t w, int unsigned len);
    logic [127:0] sig;
    sig = {sig_high, sig_low};
    for (int j = 0; j < len; j++) begin
      if (sig_care[j] && w[len-1-j] != sig[j*8 +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_region();
    recent       = '0;
    region_count = '0;
    region_hit   = 1'b0;
    hit_offset   = '0;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic last);
    logic         saturated;
    int unsigned  len;
    scan_result_t res;
    saturated = (region_count == '1);
    len = (sig_len > mbps_pkg::MAX_PATTERN_BYTES) ? mbps_pkg::MAX_PATTERN_BYTES : sig_len;
    recent = {recent[mbps_pkg::MAX_PATTERN_BYTES-2:0], b};
    if (!saturated) region_count = region_count + 1'b1;
    if (!saturated && !region_hit && len > 0 && region_count >= len) begin
      if (signature_fits(recent, len)) begin
        region_hit = 1'b1;
        hit_offset = region_count - len;
      end
    end
    if (last) begin
      res.found  = region_hit;
      res.offset = region_hit ? hit_offset[mbps_pkg::RES_OFFSET_W-1:0] : '0;
      pending_results.insert(pending_results.size(), res);
      clear_region();
    end
  endtask

  task automatic log_fault(input string what);
    faults++;
    if (faults <= 10) $display("[%0t] %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    scan_result_t want;
    if (!rst_n) begin
      sig_low  = '0;
      sig_high = '0;
      sig_care = 16'hFFFF;
      sig_len  = 5'd1;
      clear_region();
      pending_results.delete();
      faults = 0;
      taken  = 0;
      hits   = 0;
    end else begin
      if (cfg_we) begin
        case (mbps_pkg::cfg_reg_t'(cfg_index))
          mbps_pkg::CFG_PATTERN_LOW:    sig_low  = cfg_wdata;
          mbps_pkg::CFG_PATTERN_HIGH:   sig_high = cfg_wdata;
          mbps_pkg::CFG_CARE_MASK:      sig_care = cfg_wdata[15:0];
          mbps_pkg::CFG_PATTERN_LENGTH: sig_len  = cfg_wdata[4:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        taken++;
        if (pending_results.size() == 0) begin
          log_fault($sformatf("unexpected result: found=%0b offset=%0d",
                              out_found, out_match_offset));
        end else begin
          want = pending_results.pop_front();
          if (want.found) hits++;
          if (out_found !== want.found || out_match_offset !== want.offset)
            log_fault($sformatf({"result %0d: expected found=%0b offset=%0d,",
                                 " got found=%0b offset=%0d"},
                                taken, want.found, want.offset, out_found,
                                out_match_offset));
        end
      end
      if (in_valid && in_ready) scan_byte(in_data_byte, in_end_of_region);
    end
    fail_count    <= faults;
    results_open  <= pending_results.size();
    results_taken <= taken;
    results_found <= hits;
  end

endmodule

// File: tb/sv/masked_byte_pattern_search_unit_tb.sv
// Testbench top for the masked byte pattern search unit: directed and random
// regions under changing signatures and flow-control pressure.
// Depends on mbps_pkg, masked_byte_pattern_search_unit and mbps_search_checker.
module masked_byte_pattern_search_unit_tb;

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              cfg_we;
  logic [mbps_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_wdata;
  logic                              in_valid;
  logic                              in_ready;
  logic [7:0]                        in_data_byte;
  logic                              in_end_of_region;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic                              out_found;
  logic [mbps_pkg::RES_OFFSET_W-1:0] out_match_offset;

  int fail_count;
  int results_open;
  int results_taken;
  int results_found;

  int           send_idle_pct = 0;
  int           stall_pct = 0;
  int           sent_items = 0;
  int           settings_used = 0;
  logic [127:0] cur_sig;
  logic [15:0]  cur_care;
  logic [4:0]   cur_len;
  logic [7:0]   region_bytes[$];

  masked_byte_pattern_search_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_region (in_end_of_region),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_match_offset (out_match_offset)
  );

  mbps_search_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_region (in_end_of_region),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_match_offset (out_match_offset),
    .fail_count       (fail_count),
    .results_open     (results_open),
    .results_taken    (results_taken),
    .results_found    (results_found)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // one byte request; valid is left high on return
  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_end_of_region <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_region();
    foreach (region_bytes[i]) push_byte(region_bytes[i], i == region_bytes.size() - 1);
  endtask

  task automatic add_byte(input logic [7:0] b);
    region_bytes.insert(region_bytes.size(), b);
  endtask

  // hold off until every result is back and the pipeline has emptied
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_open != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input mbps_pkg::cfg_reg_t idx,
                           input logic [mbps_pkg::CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [127:0] sig, input logic [15:0] care,
                              input logic [4:0] len);
    cfg_write(mbps_pkg::CFG_PATTERN_LOW, sig[63:0]);
    cfg_write(mbps_pkg::CFG_PATTERN_HIGH, sig[127:64]);
    cfg_write(mbps_pkg::CFG_CARE_MASK, {48'd0, care});
    cfg_write(mbps_pkg::CFG_PATTERN_LENGTH, {59'd0, len});
    cfg_we   <= 1'b0;
    cur_sig  = sig;
    cur_care = care;
    cur_len  = len;
    settings_used++;
  endtask

  task automatic reconfigure_random();
    logic [127:0] sig;
    logic [15:0]  care;
    logic [4:0]   len;
    case ($urandom_range(0, 4))
      0: sig = '0;
      1: sig = '1;
      2: for (int k = 0; k < 16; k++) sig[k*8 +: 8] = 8'($urandom_range(0, 3));
      default: sig = {$urandom, $urandom, $urandom, $urandom};
    endcase
    case ($urandom_range(0, 3))
      0: care = 16'h0000;
      1: care = 16'hFFFF;
      default: care = 16'($urandom);
    endcase
    case ($urandom_range(0, 6))
      0: len = 5'd0;
      1: len = 5'd1;
      2: len = 5'd16;
      3: len = 5'($urandom_range(17, 31));
      default: len = 5'($urandom_range(2, 15));
    endcase
    apply_config(sig, care, len);
  endtask

  // filler that often reuses signature bytes so near-misses are common
  function automatic logic [7:0] stray_byte();
    int unsigned k;
    k = $urandom_range(0, 15);
    if ($urandom_range(0, 1)) return cur_sig[k*8 +: 8];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic make_region();
    int unsigned eff;
    int unsigned lead;
    int unsigned tail;
    int unsigned shape;
    region_bytes.delete();
    eff   = (cur_len > mbps_pkg::MAX_PATTERN_BYTES) ? mbps_pkg::MAX_PATTERN_BYTES : cur_len;
    shape = $urandom_range(0, 9);
    lead  = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    if ($urandom_range(0, 15) == 0) lead = $urandom_range(13, 60);
    tail  = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 8);
    repeat (lead) add_byte(stray_byte());
    if (shape < 7) begin
      // embedded signature; shape 6 cuts it short
      for (int j = 0; j < eff; j++) begin
        if (shape == 6 && j == eff - 1) break;
        add_byte(cur_care[j] ? cur_sig[j*8 +: 8] : 8'($urandom_range(0, 255)));
      end
    end else begin
      tail = tail + $urandom_range(0, 20);
    end
    repeat (tail) add_byte(stray_byte());
    if (region_bytes.size() == 0) add_byte(stray_byte());
  endtask

  initial begin
    int base;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = mbps_pkg::CFG_PATTERN_LOW;
    cfg_wdata        = '0;
    in_valid         = 1'b0;
    in_data_byte     = '0;
    in_end_of_region = 1'b0;
    cur_sig          = '0;
    cur_care         = 16'hFFFF;
    cur_len          = 5'd1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: single zero byte, care on
    region_bytes = '{8'h00};
    send_region();
    region_bytes = '{8'hFF, 8'h00};
    send_region();
    region_bytes = '{8'hFF};
    send_region();
    // zero length never matches
    drain();
    apply_config('0, 16'hFFFF, 5'd0);
    region_bytes = '{8'h00, 8'h00};
    send_region();
    // overlong length clamps to 16, all wildcards
    drain();
    apply_config('1, 16'h0000, 5'd31);
    region_bytes.delete();
    for (int i = 0; i < 16; i++) add_byte(i[0] ? 8'hFF : 8'h00);
    send_region();
    // region shorter than the signature
    region_bytes = '{8'h80, 8'h7F, 8'h01};
    send_region();

    base = sent_items;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 76; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      while (sent_items < base + 375 * (p + 1)) begin
        drain();
        reconfigure_random();
        repeat ($urandom_range(1, 6)) begin
          make_region();
          send_region();
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d bytes under %0d register settings; %0d regions reported, %0d matched.",
             sent_items, settings_used, results_taken, results_found);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: masked_byte_pattern_search_unit.f
rtl/core/mbps_pkg.sv
rtl/core/mbps_window_match.sv
rtl/core/masked_byte_pattern_search_unit.sv
tb/sv/mbps_search_checker.sv
tb/sv/masked_byte_pattern_search_unit_tb.sv
